/* rtl/gbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and the control store of the go-back-n window engine.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // event codes of an input item
  typedef enum logic [1:0] {
    KIND_FRAME     = 2'd0,
    KIND_CKSUM_ERR = 2'd1,
    KIND_TIMEOUT   = 2'd2,
    KIND_PACKET    = 2'd3
  } kind_t;

  // action codes of a result item
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_DELIVER = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_REJECT  = 3'd4
  } action_t;

  // control store addresses
  typedef enum logic [3:0] {
    ST_FETCH,
    ST_DISPATCH,
    ST_REJECT,
    ST_SEND_NEW,
    ST_RX,
    ST_DELIVER,
    ST_RX_NODEL,
    ST_STOP,
    ST_TIMEOUT,
    ST_NONE,
    ST_RESEND
  } step_t;

  // branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_KIND,
    C_SEQ_MATCH,
    C_REM_ZERO,
    C_REM_ONE
  } cond_t;

  typedef enum logic [1:0] {
    SEQ_ZERO,
    SEQ_NTS,
    SEQ_OLDEST
  } seq_sel_t;

  typedef enum logic [1:0] {
    DATA_ZERO,
    DATA_PAYLOAD,
    DATA_STORE
  } data_sel_t;

  typedef enum logic [1:0] {
    LAST_ONE,
    LAST_REM_ZERO,
    LAST_REM_ONE
  } last_sel_t;

  // one control word
  typedef struct packed {
    logic      accept;
    logic      emit;
    action_t   act;
    seq_sel_t  seq_sel;
    logic      ack_en;
    data_sel_t data_sel;
    last_sel_t last_sel;
    logic      store_wr;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      nts_inc;
    logic      nts_load_old;
    logic      old_inc;
    logic      rxe_inc;
    logic      rem_dec;
    logic      dispatch;
    cond_t     cond;
    step_t     on_true;
    step_t     on_false;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic  out_free;
    logic  in_take;
    logic  seq_match;
    logic  rem_zero;
    logic  rem_one;
    logic  full;
    kind_t kind;
  } status_t;

  // control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '0;
    c.cond     = C_ALWAYS;
    c.on_true  = ST_FETCH;
    c.on_false = ST_FETCH;
    unique case (s)
      ST_FETCH: begin
        c.accept   = 1'b1;
        c.cond     = C_ACCEPT;
        c.on_true  = ST_DISPATCH;
        c.on_false = ST_FETCH;
      end
      ST_DISPATCH: begin
        c.dispatch = 1'b1;
        c.cond     = C_KIND;
      end
      ST_REJECT: begin
        c.emit     = 1'b1;
        c.act      = ACT_REJECT;
        c.last_sel = LAST_ONE;
      end
      ST_SEND_NEW: begin
        c.emit     = 1'b1;
        c.act      = ACT_SEND;
        c.seq_sel  = SEQ_NTS;
        c.ack_en   = 1'b1;
        c.data_sel = DATA_PAYLOAD;
        c.last_sel = LAST_ONE;
        c.store_wr = 1'b1;
        c.cnt_inc  = 1'b1;
        c.nts_inc  = 1'b1;
      end
      ST_RX: begin
        c.cond     = C_SEQ_MATCH;
        c.on_true  = ST_DELIVER;
        c.on_false = ST_RX_NODEL;
      end
      ST_DELIVER: begin
        c.emit     = 1'b1;
        c.act      = ACT_DELIVER;
        c.data_sel = DATA_PAYLOAD;
        c.last_sel = LAST_REM_ZERO;
        c.rxe_inc  = 1'b1;
        c.cond     = C_REM_ZERO;
        c.on_true  = ST_FETCH;
        c.on_false = ST_STOP;
      end
      ST_RX_NODEL: begin
        c.cond     = C_REM_ZERO;
        c.on_true  = ST_NONE;
        c.on_false = ST_STOP;
      end
      ST_STOP: begin
        c.emit     = 1'b1;
        c.act      = ACT_STOP;
        c.seq_sel  = SEQ_OLDEST;
        c.last_sel = LAST_REM_ONE;
        c.cnt_dec  = 1'b1;
        c.old_inc  = 1'b1;
        c.rem_dec  = 1'b1;
        c.cond     = C_REM_ONE;
        c.on_true  = ST_FETCH;
        c.on_false = ST_STOP;
      end
      ST_TIMEOUT: begin
        c.nts_load_old = 1'b1;
        c.cond         = C_REM_ZERO;
        c.on_true      = ST_NONE;
        c.on_false     = ST_RESEND;
      end
      ST_NONE: begin
        c.emit     = 1'b1;
        c.act      = ACT_NONE;
        c.last_sel = LAST_ONE;
      end
      ST_RESEND: begin
        c.emit     = 1'b1;
        c.act      = ACT_SEND;
        c.seq_sel  = SEQ_NTS;
        c.ack_en   = 1'b1;
        c.data_sel = DATA_STORE;
        c.last_sel = LAST_REM_ONE;
        c.nts_inc  = 1'b1;
        c.rem_dec  = 1'b1;
        c.cond     = C_REM_ONE;
        c.on_true  = ST_FETCH;
        c.on_false = ST_RESEND;
      end
      default: begin
        c.cond = C_ALWAYS;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/gbn_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_in_if
// Event channel into the window engine: valid/ready plus one event item.
// ----------------------------------------------------------------------------
interface gbn_in_if #(
  parameter int SEQ_BITS  = 3,
  parameter int PKT_WIDTH = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [PKT_WIDTH-1:0] payload;
  logic [SEQ_BITS-1:0]  rx_seq;
  logic [SEQ_BITS-1:0]  rx_ack;

  modport source (output valid, kind, payload, rx_seq, rx_ack, input ready);
  modport sink   (input valid, kind, payload, rx_seq, rx_ack, output ready);
endinterface
`default_nettype wire

/* rtl/gbn_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_out_if
// Result channel out of the window engine: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface gbn_out_if #(
  parameter int SEQ_BITS  = 3,
  parameter int PKT_WIDTH = 32
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           action;
  logic [SEQ_BITS-1:0]  seq;
  logic [SEQ_BITS-1:0]  ack;
  logic [PKT_WIDTH-1:0] data_word;
  logic                 net_enable;
  logic                 last;

  modport source (output valid, action, seq, ack, data_word, net_enable, last,
                  input ready);
  modport sink   (input valid, action, seq, ack, data_word, net_enable, last,
                  output ready);
endinterface
`default_nettype wire

/* rtl/gbn_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sequencer
// Step counter over the control store with conditional and multiway jumps.
// ----------------------------------------------------------------------------
module gbn_sequencer
  import gbn_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t st,
  output ctrl_t        ctrl,
  output step_t        step
);

  step_t step_next;
  step_t kind_target;
  logic  stall;

  // current control word
  assign ctrl  = ucode(step);
  assign stall = ctrl.emit && !st.out_free;

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // multiway target on the event code
  always_comb begin
    unique case (st.kind)
      KIND_PACKET:    kind_target = st.full ? ST_REJECT : ST_SEND_NEW;
      KIND_FRAME:     kind_target = ST_RX;
      KIND_TIMEOUT:   kind_target = ST_TIMEOUT;
      KIND_CKSUM_ERR: kind_target = ST_NONE;
      default:        kind_target = ST_NONE;
    endcase
  end

  // next step
  always_comb begin
    step_next = step;
    if (!stall) begin
      unique case (ctrl.cond)
        C_ALWAYS:    step_next = ctrl.on_true;
        C_ACCEPT:    step_next = st.in_take ? ctrl.on_true : ctrl.on_false;
        C_KIND:      step_next = kind_target;
        C_SEQ_MATCH: step_next = st.seq_match ? ctrl.on_true : ctrl.on_false;
        C_REM_ZERO:  step_next = st.rem_zero ? ctrl.on_true : ctrl.on_false;
        C_REM_ONE:   step_next = st.rem_one ? ctrl.on_true : ctrl.on_false;
        default:     step_next = ST_FETCH;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/gbn_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_datapath
// Window registers, packet buffer, item latch and result register, all
// driven by the control word of the current step.
// ----------------------------------------------------------------------------
module gbn_datapath
  import gbn_pkg::*;
#(
  parameter int SEQ_BITS  = 3,
  parameter int PKT_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire ctrl_t  ctrl,
  output status_t     st,
  gbn_in_if.sink      req,
  gbn_out_if.source   rsp
);

  localparam int                  Depth  = 1 << SEQ_BITS;
  localparam logic [SEQ_BITS-1:0] MaxSeq = '1;
  localparam logic [SEQ_BITS-1:0] One    = SEQ_BITS'(1);

  // latched item
  kind_t                kind_q;
  logic [PKT_WIDTH-1:0] payload_q;
  logic [SEQ_BITS-1:0]  rx_seq_q;
  logic [SEQ_BITS-1:0]  rx_ack_q;

  // window state
  logic [SEQ_BITS-1:0]  nts;
  logic [SEQ_BITS-1:0]  nts_next;
  logic [SEQ_BITS-1:0]  oldest;
  logic [SEQ_BITS-1:0]  rxe;
  logic [SEQ_BITS-1:0]  cnt;
  logic [SEQ_BITS-1:0]  rem;
  logic                 ne_q;

  // packet buffer
  logic [PKT_WIDTH-1:0] store [Depth];
  logic [PKT_WIDTH-1:0] rdata;

  // result register
  logic                 out_valid;
  action_t              act_q;
  logic [SEQ_BITS-1:0]  seq_q;
  logic [SEQ_BITS-1:0]  ack_q;
  logic [PKT_WIDTH-1:0] data_q;
  logic                 ne_out_q;
  logic                 last_q;

  logic                 take;
  logic                 out_free;
  logic                 fire;
  logic [SEQ_BITS-1:0]  ack_off;
  logic                 in_win;
  logic [SEQ_BITS-1:0]  freed;
  logic [SEQ_BITS-1:0]  cnt_after;
  logic                 full;

  assign take     = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign fire     = !(ctrl.emit && !out_free);
  assign full     = (cnt == MaxSeq);

  // ack window check: outside a resend the window [oldest, nts) spans cnt entries
  assign ack_off = rx_ack_q - oldest;
  assign in_win  = (ack_off < cnt);
  assign freed   = in_win ? ack_off + One : '0;

  // outstanding count once the whole event is done
  always_comb begin
    case (kind_q)
      KIND_PACKET: cnt_after = full ? cnt : cnt + One;
      KIND_FRAME:  cnt_after = cnt - freed;
      default:     cnt_after = cnt;
    endcase
  end

  // status toward the sequencer
  assign st.out_free  = out_free;
  assign st.in_take   = take;
  assign st.seq_match = (rx_seq_q == rxe);
  assign st.rem_zero  = (rem == '0);
  assign st.rem_one   = (rem == One);
  assign st.full      = full;
  assign st.kind      = kind_q;

  assign req.ready = ctrl.accept;

  // item latch
  always_ff @(posedge clk) begin
    if (take) begin
      kind_q    <= kind_t'(req.kind);
      payload_q <= req.payload;
      rx_seq_q  <= req.rx_seq;
      rx_ack_q  <= req.rx_ack;
    end
  end

  // next send pointer, also the buffer read address
  always_comb begin
    nts_next = nts;
    if (fire && ctrl.nts_load_old) begin
      nts_next = oldest;
    end else if (fire && ctrl.nts_inc) begin
      nts_next = nts + One;
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nts    <= '0;
      oldest <= '0;
      rxe    <= '0;
      cnt    <= '0;
      rem    <= '0;
      ne_q   <= 1'b1;
    end else begin
      nts <= nts_next;
      if (fire) begin
        if (ctrl.old_inc) begin
          oldest <= oldest + One;
        end
        if (ctrl.rxe_inc) begin
          rxe <= rxe + One;
        end
        if (ctrl.cnt_inc) begin
          cnt <= cnt + One;
        end else if (ctrl.cnt_dec) begin
          cnt <= cnt - One;
        end
        if (ctrl.dispatch) begin
          rem  <= (kind_q == KIND_TIMEOUT) ? cnt : freed;
          ne_q <= (cnt_after != MaxSeq);
        end else if (ctrl.rem_dec) begin
          rem <= rem - One;
        end
      end
    end
  end

  // packet buffer, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (fire && ctrl.store_wr) begin
      store[nts] <= payload_q;
    end
    rdata <= store[nts_next];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.emit) begin
      act_q    <= ctrl.act;
      ack_q    <= ctrl.ack_en ? rxe + MaxSeq : '0;
      ne_out_q <= ne_q;
      case (ctrl.seq_sel)
        SEQ_NTS:    seq_q <= nts;
        SEQ_OLDEST: seq_q <= oldest;
        default:    seq_q <= '0;
      endcase
      case (ctrl.data_sel)
        DATA_PAYLOAD: data_q <= payload_q;
        DATA_STORE:   data_q <= rdata;
        default:      data_q <= '0;
      endcase
      case (ctrl.last_sel)
        LAST_REM_ZERO: last_q <= (rem == '0);
        LAST_REM_ONE:  last_q <= (rem == One);
        default:       last_q <= 1'b1;
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.action     = act_q;
  assign rsp.seq        = seq_q;
  assign rsp.ack        = ack_q;
  assign rsp.data_word  = data_q;
  assign rsp.net_enable = ne_out_q;
  assign rsp.last       = last_q;

endmodule
`default_nettype wire

/* rtl/go_back_n_window_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_window_engine_unit
// Go-back-n sliding-window endpoint run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One event item enters on req and produces one or more result items on rsp,
// the final one flagged by last. The sequencer takes an item in its fetch step
// and decodes it in the next cycle; a packet, a rejected packet or a checksum
// error then gives its single result, an arriving frame passes its sequence
// check, then a no-delivery step if it delivers nothing, and gives one result
// for the delivery and each freed buffer (a none result if neither), and a
// timeout rewinds the send pointer and resends one frame per cycle, while rsp
// does not stall, out of the packet buffer's single read port.
// The next item is accepted right after the last result is loaded into the
// result register, while that result may still wait on rsp.
module go_back_n_window_engine_unit
  import gbn_pkg::*;
#(
  parameter int SEQ_BITS  = 3,
  parameter int PKT_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  gbn_in_if.sink    req,
  gbn_out_if.source rsp
);

  ctrl_t   ctrl;
  status_t st;
  step_t   step;

  // control
  gbn_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl),
    .step (step)
  );

  // datapath
  gbn_datapath #(
    .SEQ_BITS  (SEQ_BITS),
    .PKT_WIDTH (PKT_WIDTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .st   (st),
    .req  (req),
    .rsp  (rsp)
  );

`ifndef ASSERT_OFF
  // an accepted item is decoded next
  a_take_decode: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (step == ST_DISPATCH))
    else $error("accepted item not decoded");

  // a result step with room in the output register always loads it
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit && st.out_free) |=> rsp.valid)
    else $error("result not loaded");

  // loop steps always have work left
  a_loop_count: assert property (@(posedge clk) disable iff (rst)
    (step == ST_STOP || step == ST_RESEND) |-> !st.rem_zero)
    else $error("loop step with nothing left");
`endif

endmodule
`default_nettype wire
